// ----- design/ntc_pkg.sv -----
package ntc_pkg;

  localparam int FEAT_W        = 24;
  localparam int CLASS_W       = 8;
  localparam int ADDR_W        = 6;
  localparam int MAX_TEMPLATES = 64;
  localparam int CNT_W         = 7;
  localparam int DIFF_W        = FEAT_W + 1;
  localparam int SQ_W          = 2 * FEAT_W + 1;
  localparam int DIST_W        = 50;
  localparam int PADDR_W       = 3;

  localparam logic KIND_WRITE    = 1'b0;
  localparam logic KIND_CLASSIFY = 1'b1;

  localparam logic [PADDR_W-1:0] REG_TEMPLATES_IN_USE = 3'h0;

  typedef struct packed {
    logic [FEAT_W-1:0]  elong;
    logic [FEAT_W-1:0]  circ;
    logic [FEAT_W-1:0]  hu;
    logic [CLASS_W-1:0] cls;
  } ntc_entry_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              load_query;
    logic              issue;
    logic [ADDR_W-1:0] rd_addr;
  } ntc_cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } ntc_stat_t;

endpackage

// ----- design/ntc_ctrl.sv -----
module ntc_ctrl
  import ntc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              kind,
  input  logic [ADDR_W-1:0] entry_index,
  input  logic [CNT_W-1:0]  templates_in_use,
  input  ntc_stat_t         stat,
  output logic              busy,
  output logic              out_valid,
  output ntc_cmd_t          cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0]  last_r, last_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]  count;
  logic              accept;

  assign count = (templates_in_use > CNT_W'(MAX_TEMPLATES)) ?
                 CNT_W'(MAX_TEMPLATES) : templates_in_use;
  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.wr_en      = accept && (kind == KIND_WRITE) &&
                     ({1'b0, entry_index} < (ADDR_W+1)'(MAX_TEMPLATES));
    cmd.wr_addr    = entry_index;
    cmd.load_query = accept && (kind == KIND_CLASSIFY);
    cmd.issue      = (state_r == ST_SCAN);
    cmd.rd_addr    = idx_r;
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    last_nxt      = last_r;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (kind == KIND_CLASSIFY)) begin
          idx_nxt  = '0;
          last_nxt = count - CNT_W'(1);
          // empty table: nothing to scan, report straight away
          state_nxt = (count == '0) ? ST_DRAIN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        idx_nxt = idx_r + ADDR_W'(1);
        if ({1'b0, idx_r} == last_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      last_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      last_r      <= last_nxt;
    end
  end

endmodule

// ----- design/ntc_datapath.sv -----
module ntc_datapath
  import ntc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  ntc_cmd_t           cmd,
  input  logic [FEAT_W-1:0]  elongation,
  input  logic [FEAT_W-1:0]  circularity,
  input  logic [FEAT_W-1:0]  hu_first,
  input  logic [CLASS_W-1:0] class_id,
  output ntc_stat_t          stat,
  output logic               found,
  output logic [CLASS_W-1:0] best_class,
  output logic [ADDR_W-1:0]  best_entry,
  output logic [DIST_W-1:0]  best_distance_sq
);

  ntc_entry_t mem [MAX_TEMPLATES];

  logic [FEAT_W-1:0]  q_elong_r, q_circ_r, q_hu_r;

  // stage 1: table read
  logic               rd_v_r;
  ntc_entry_t         rd_q_r;
  logic [ADDR_W-1:0]  rd_idx_r;
  // stage 2: differences
  logic               df_v_r;
  logic [DIFF_W-1:0]  df_e_r, df_c_r, df_h_r;
  logic [ADDR_W-1:0]  df_idx_r;
  logic [CLASS_W-1:0] df_cls_r;
  // stage 3: squares
  logic               sq_v_r;
  logic [SQ_W-1:0]    sq_e_r, sq_c_r, sq_h_r;
  logic [ADDR_W-1:0]  sq_idx_r;
  logic [CLASS_W-1:0] sq_cls_r;
  // stage 4: sum
  logic               sm_v_r;
  logic [DIST_W-1:0]  sm_r;
  logic [ADDR_W-1:0]  sm_idx_r;
  logic [CLASS_W-1:0] sm_cls_r;

  logic               found_r;
  logic [DIST_W-1:0]  best_d_r;
  logic [ADDR_W-1:0]  best_idx_r;
  logic [CLASS_W-1:0] best_cls_r;

  logic [DIFF_W-1:0]  mag_e, mag_c, mag_h;
  logic               better;

  function automatic logic [DIFF_W-1:0] sdiff(input logic [FEAT_W-1:0] a,
                                              input logic [FEAT_W-1:0] b);
    return {a[FEAT_W-1], a} - {b[FEAT_W-1], b};
  endfunction

  // magnitude of a 25-bit difference; the most negative value maps to 2^24
  function automatic logic [DIFF_W-1:0] mag(input logic [DIFF_W-1:0] d);
    return d[DIFF_W-1] ? (~d + DIFF_W'(1)) : d;
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= '{elong: elongation, circ: circularity,
                            hu: hu_first, cls: class_id};
    end
    if (cmd.issue) begin
      rd_q_r <= mem[cmd.rd_addr];
    end
  end

  assign mag_e  = mag(df_e_r);
  assign mag_c  = mag(df_c_r);
  assign mag_h  = mag(df_h_r);
  assign better = !found_r || (sm_r < best_d_r);

  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      q_elong_r <= elongation;
      q_circ_r  <= circularity;
      q_hu_r    <= hu_first;
    end
    rd_idx_r <= cmd.rd_addr;

    df_e_r   <= sdiff(q_elong_r, rd_q_r.elong);
    df_c_r   <= sdiff(q_circ_r, rd_q_r.circ);
    df_h_r   <= sdiff(q_hu_r, rd_q_r.hu);
    df_idx_r <= rd_idx_r;
    df_cls_r <= rd_q_r.cls;

    sq_e_r   <= SQ_W'(mag_e * mag_e);
    sq_c_r   <= SQ_W'(mag_c * mag_c);
    sq_h_r   <= SQ_W'(mag_h * mag_h);
    sq_idx_r <= df_idx_r;
    sq_cls_r <= df_cls_r;

    sm_r     <= DIST_W'(sq_e_r) + DIST_W'(sq_c_r) + DIST_W'(sq_h_r);
    sm_idx_r <= sq_idx_r;
    sm_cls_r <= sq_cls_r;

    if (cmd.load_query) begin
      best_d_r   <= '0;
      best_idx_r <= '0;
      best_cls_r <= '0;
    end else if (sm_v_r && better) begin
      best_d_r   <= sm_r;
      best_idx_r <= sm_idx_r;
      best_cls_r <= sm_cls_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r  <= 1'b0;
      df_v_r  <= 1'b0;
      sq_v_r  <= 1'b0;
      sm_v_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      rd_v_r <= cmd.issue;
      df_v_r <= rd_v_r;
      sq_v_r <= df_v_r;
      sm_v_r <= sq_v_r;
      if (cmd.load_query) begin
        found_r <= 1'b0;
      end else if (sm_v_r) begin
        found_r <= 1'b1;
      end
    end
  end

  assign stat.pipe_busy  = rd_v_r || df_v_r || sq_v_r || sm_v_r;
  assign found           = found_r;
  assign best_class      = best_cls_r;
  assign best_entry      = best_idx_r;
  assign best_distance_sq = best_d_r;

endmodule

// ----- design/nearest_template_classifier.sv -----
// channel   direction  handshake                       payload
// in_*      in         start & !busy accepts a request  kind, entry, 3 features, class
// out_*     out        out_valid, one cycle, no stall   found, class, entry, distance
// cfg       in         APB write, pready tied high      templates_in_use at 0x0
//
// A write request leaves busy low, so requests may follow back to back.
// A classify request scans count entries before out_valid, count being templates_in_use
// saturated at 64; with a count of 0 nothing is scanned.
// The single table read port yields one entry a cycle into a 4-deep distance pipe.
// rst_n is synchronous; it clears control state and the register, not the table.
// The receiver cannot stall; out_* hold their value until the next classify request.
module nearest_template_classifier
  import ntc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_kind,
  input  logic [ADDR_W-1:0]  in_entry_index,
  input  logic [FEAT_W-1:0]  in_elongation,
  input  logic [FEAT_W-1:0]  in_circularity,
  input  logic [FEAT_W-1:0]  in_hu_first,
  input  logic [CLASS_W-1:0] in_class_id,
  output logic               out_valid,
  output logic               out_found,
  output logic [CLASS_W-1:0] out_best_class,
  output logic [ADDR_W-1:0]  out_best_entry,
  output logic [DIST_W-1:0]  out_best_distance_sq,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [CNT_W-1:0] templates_r;
  ntc_cmd_t         cmd;
  ntc_stat_t        stat;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_TEMPLATES_IN_USE) ? {{(32-CNT_W){1'b0}}, templates_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      templates_r <= '0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr == REG_TEMPLATES_IN_USE)) begin
      templates_r <= pwdata[CNT_W-1:0];
    end
  end

  ntc_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .kind             (in_kind),
    .entry_index      (in_entry_index),
    .templates_in_use (templates_r),
    .stat             (stat),
    .busy             (busy),
    .out_valid        (out_valid),
    .cmd              (cmd)
  );

  ntc_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .elongation       (in_elongation),
    .circularity      (in_circularity),
    .hu_first         (in_hu_first),
    .class_id         (in_class_id),
    .stat             (stat),
    .found            (out_found),
    .best_class       (out_best_class),
    .best_entry       (out_best_entry),
    .best_distance_sq (out_best_distance_sq)
  );

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
  import ntc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_REQUESTS = 1850;
  localparam int CALM_TAIL = 150;
  // settle time after the last classify result; the scan count saturates at 64
  localparam int SETTLE_CYCLES = 80;

  localparam logic [FEAT_W-1:0] FEAT_MIN = {1'b1, {(FEAT_W-1){1'b0}}};
  localparam logic [FEAT_W-1:0] FEAT_MAX = {1'b0, {(FEAT_W-1){1'b1}}};
  localparam logic [FEAT_W-1:0] FEAT_ZERO = '0;

  typedef struct packed {
    logic              found;
    logic [CLASS_W-1:0] cls;
    logic [ADDR_W-1:0]  entry;
    logic [DIST_W-1:0]  distance;
  } match_t;

  localparam match_t NO_MATCH = '0;
  // all three features span the full range: 3 * (2^24 - 1)^2
  localparam logic [DIST_W-1:0] FULL_SPAN_DIST = 50'd844424829468675;

  typedef enum logic {ROW_REQUEST, ROW_CONFIG} row_op_t;

  typedef struct packed {
    row_op_t            op;
    logic               kind;
    logic [ADDR_W-1:0]  idx;
    logic [FEAT_W-1:0]  elong;
    logic [FEAT_W-1:0]  circ;
    logic [FEAT_W-1:0]  hu;
    logic [CLASS_W-1:0] cls;
    logic [CNT_W-1:0]   count;
    logic               typed;
    match_t             want;
  } row_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               in_kind = KIND_WRITE;
  logic [ADDR_W-1:0]  in_entry_index = '0;
  logic [FEAT_W-1:0]  in_elongation = '0;
  logic [FEAT_W-1:0]  in_circularity = '0;
  logic [FEAT_W-1:0]  in_hu_first = '0;
  logic [CLASS_W-1:0] in_class_id = '0;
  logic               out_valid;
  logic               out_found;
  logic [CLASS_W-1:0] out_best_class;
  logic [ADDR_W-1:0]  out_best_entry;
  logic [DIST_W-1:0]  out_best_distance_sq;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  nearest_template_classifier dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_kind             (in_kind),
    .in_entry_index      (in_entry_index),
    .in_elongation       (in_elongation),
    .in_circularity      (in_circularity),
    .in_hu_first         (in_hu_first),
    .in_class_id         (in_class_id),
    .out_valid           (out_valid),
    .out_found           (out_found),
    .out_best_class      (out_best_class),
    .out_best_entry      (out_best_entry),
    .out_best_distance_sq(out_best_distance_sq),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  // shadow of the template table and the scan count
  logic [FEAT_W-1:0]  tmpl_elong [MAX_TEMPLATES];
  logic [FEAT_W-1:0]  tmpl_circ [MAX_TEMPLATES];
  logic [FEAT_W-1:0]  tmpl_hu [MAX_TEMPLATES];
  logic [CLASS_W-1:0] tmpl_class [MAX_TEMPLATES];
  int unsigned        scan_count = 0;

  match_t pending_matches [$];
  match_t got_match;
  int     mismatches = 0;
  int     requests_accepted = 0;
  int     cycle_count = 0;
  bit     idling = 1'b0;
  int     phase = 0;

  row_t directed_rows [0:18] = '{
    '{ROW_REQUEST, KIND_CLASSIFY, 6'd63, FEAT_MAX, FEAT_MAX, FEAT_MAX, 8'hFF, 7'd0, 1'b1,
      NO_MATCH},
    '{ROW_CONFIG, KIND_WRITE, 6'd0, FEAT_ZERO, FEAT_ZERO, FEAT_ZERO, 8'h00, 7'd0, 1'b0,
      NO_MATCH},
    '{ROW_REQUEST, KIND_CLASSIFY, 6'd0, FEAT_MIN, FEAT_MIN, FEAT_MIN, 8'h00, 7'd0, 1'b1,
      NO_MATCH},
    '{ROW_REQUEST, KIND_WRITE, 6'd0, FEAT_MIN, FEAT_MIN, FEAT_MIN, 8'hFF, 7'd0, 1'b0,
      NO_MATCH},
    '{ROW_REQUEST, KIND_WRITE, 6'd1, FEAT_MAX, FEAT_MAX, FEAT_MAX, 8'h00, 7'd0, 1'b0,
      NO_MATCH},
    '{ROW_REQUEST, KIND_WRITE, 6'd2, FEAT_ZERO, FEAT_ZERO, FEAT_ZERO, 8'hA5, 7'd0, 1'b0,
      NO_MATCH},
    '{ROW_REQUEST, KIND_WRITE, 6'd3, FEAT_ZERO, FEAT_ZERO, FEAT_ZERO, 8'h5A, 7'd0, 1'b0,
      NO_MATCH},
    '{ROW_CONFIG, KIND_WRITE, 6'd0, FEAT_ZERO, FEAT_ZERO, FEAT_ZERO, 8'h00, 7'd1, 1'b0,
      NO_MATCH},
    '{ROW_REQUEST, KIND_CLASSIFY, 6'd0, FEAT_MAX, FEAT_MAX, FEAT_MAX, 8'h00, 7'd0, 1'b1,
      '{1'b1, 8'hFF, 6'd0, FULL_SPAN_DIST}},
    '{ROW_REQUEST, KIND_CLASSIFY, 6'd0, FEAT_MIN, FEAT_MIN, FEAT_MIN, 8'h00, 7'd0, 1'b1,
      '{1'b1, 8'hFF, 6'd0, 50'd0}},
    '{ROW_REQUEST, KIND_CLASSIFY, 6'd63, FEAT_ZERO, FEAT_ZERO, FEAT_ZERO, 8'h33, 7'd0, 1'b0,
      NO_MATCH},
    '{ROW_CONFIG, KIND_WRITE, 6'd0, FEAT_ZERO, FEAT_ZERO, FEAT_ZERO, 8'h00, 7'd4, 1'b0,
      NO_MATCH},
    // entries 2 and 3 tie at zero distance: the earlier one wins
    '{ROW_REQUEST, KIND_CLASSIFY, 6'd0, FEAT_ZERO, FEAT_ZERO, FEAT_ZERO, 8'h00, 7'd0, 1'b1,
      '{1'b1, 8'hA5, 6'd2, 50'd0}},
    '{ROW_REQUEST, KIND_CLASSIFY, 6'd0, FEAT_MAX, FEAT_MAX, FEAT_MAX, 8'h00, 7'd0, 1'b1,
      '{1'b1, 8'h00, 6'd1, 50'd0}},
    '{ROW_REQUEST, KIND_CLASSIFY, 6'd0, 24'h000001, 24'hFFFFFF, FEAT_ZERO, 8'h00, 7'd0, 1'b0,
      NO_MATCH},
    '{ROW_REQUEST, KIND_CLASSIFY, 6'd0, 24'hAAAAAA, 24'h555555, 24'h7FFF00, 8'h00, 7'd0, 1'b0,
      NO_MATCH},
    '{ROW_REQUEST, KIND_WRITE, 6'd3, 24'h000001, 24'hFFFFFF, FEAT_ZERO, 8'hC3, 7'd0, 1'b0,
      NO_MATCH},
    '{ROW_REQUEST, KIND_CLASSIFY, 6'd0, 24'h000001, 24'hFFFFFF, FEAT_ZERO, 8'h00, 7'd0, 1'b0,
      NO_MATCH},
    '{ROW_REQUEST, KIND_CLASSIFY, 6'd0, FEAT_ZERO, FEAT_ZERO, 24'h000001, 8'h00, 7'd0, 1'b0,
      NO_MATCH}
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic longint feature_sq(logic [FEAT_W-1:0] a, logic [FEAT_W-1:0] b);
    longint d;
    d = longint'($signed(a)) - longint'($signed(b));
    return d * d;
  endfunction

  function automatic match_t nearest_match(logic [FEAT_W-1:0] qe, logic [FEAT_W-1:0] qc,
                                           logic [FEAT_W-1:0] qh);
    match_t m;
    longint d;
    longint best;
    int n;
    m = NO_MATCH;
    best = 0;
    n = (scan_count > MAX_TEMPLATES) ? MAX_TEMPLATES : scan_count;
    for (int i = 0; i < n; i++) begin
      d = feature_sq(qe, tmpl_elong[i]) + feature_sq(qc, tmpl_circ[i])
        + feature_sq(qh, tmpl_hu[i]);
      if (!m.found || d < best) begin
        m.found = 1'b1;
        m.cls = tmpl_class[i];
        m.entry = ADDR_W'(i);
        best = d;
      end
    end
    if (m.found)
      m.distance = best[DIST_W-1:0];
    return m;
  endfunction

  task automatic check_field(input string what, input logic [63:0] exp, input logic [63:0] act);
    if (act !== exp) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, exp, act);
    end
  endtask

  // results are stable for the whole strobe cycle; sample mid-cycle
  always @(negedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_matches.size() == 0) begin
        mismatches++;
        $display("%0t: result with no request outstanding: expected none, actual %0h",
                 $time, {out_found, out_best_class, out_best_entry, out_best_distance_sq});
      end else begin
        got_match = pending_matches.pop_front();
        check_field("found", 64'(got_match.found), 64'(out_found));
        check_field("best_class", 64'(got_match.cls), 64'(out_best_class));
        check_field("best_entry", 64'(got_match.entry), 64'(out_best_entry));
        check_field("best_distance_sq", 64'(got_match.distance), 64'(out_best_distance_sq));
      end
    end
  end

  function automatic int pick_gap();
    if (!idling || $urandom_range(0, 5) != 0)
      return 0;
    return $urandom_range(1, 17);
  endfunction

  function automatic logic [FEAT_W-1:0] rand_feature();
    case ($urandom_range(0, 7))
      0: return FEAT_MIN;
      1: return FEAT_MAX;
      2: return FEAT_ZERO;
      3: return '1;
      default: return FEAT_W'($urandom);
    endcase
  endfunction

  // called right after a rising edge; returns at the edge that takes the request
  task automatic send_request(input logic kind, input logic [ADDR_W-1:0] idx,
                              input logic [FEAT_W-1:0] e, input logic [FEAT_W-1:0] c,
                              input logic [FEAT_W-1:0] h, input logic [CLASS_W-1:0] cls,
                              input bit typed, input match_t want, input int gap);
    bit was_busy;
    match_t expected;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_kind        <= kind;
    in_entry_index <= idx;
    in_elongation  <= e;
    in_circularity <= c;
    in_hu_first    <= h;
    in_class_id    <= cls;
    do begin
      @(negedge clk) was_busy = busy;
      @(posedge clk);
    end while (was_busy);
    requests_accepted++;
    if (kind == KIND_WRITE) begin
      tmpl_elong[idx] = e;
      tmpl_circ[idx]  = c;
      tmpl_hu[idx]    = h;
      tmpl_class[idx] = cls;
    end else begin
      expected = typed ? want : nearest_match(e, c, h);
      pending_matches.insert(pending_matches.size(), expected);
    end
  endtask

  // pause the sender until every classify result is back and the block is quiet
  task automatic drain();
    start <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CNT_W-1:0] value);
    logic [31:0] upper;
    logic [31:0] rd;
    bit ready;
    upper = $urandom;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_TEMPLATES_IN_USE;
    pwdata  <= {upper[31:CNT_W], value};
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk) ready = pready;
      @(posedge clk);
    end while (!ready);
    scan_count = value;
    // read back through a fresh setup phase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk) begin
        ready = pready;
        rd = prdata;
      end
      @(posedge clk);
    end while (!ready);
    psel    <= 1'b0;
    penable <= 1'b0;
    check_field("templates_in_use readback", 64'(value), 64'(rd));
  endtask

  task automatic random_request();
    logic [FEAT_W-1:0] e, c, h;
    int n, j;
    n = (scan_count > MAX_TEMPLATES) ? MAX_TEMPLATES : scan_count;
    if ($urandom_range(0, 1) == 0) begin
      // copy only from entries already written (entry 0 always is)
      j = (n > 0) ? $urandom_range(0, n - 1) : 0;
      if ($urandom_range(0, 3) == 0) begin
        // duplicate features of another entry to provoke ties
        e = tmpl_elong[j];
        c = tmpl_circ[j];
        h = tmpl_hu[j];
      end else begin
        e = rand_feature();
        c = rand_feature();
        h = rand_feature();
      end
      send_request(KIND_WRITE, ADDR_W'($urandom), e, c, h, CLASS_W'($urandom), 1'b0,
                   NO_MATCH, pick_gap());
    end else begin
      j = (n > 0) ? $urandom_range(0, n - 1) : 0;
      case ($urandom_range(0, 4))
        0: begin
          e = tmpl_elong[j];
          c = tmpl_circ[j];
          h = tmpl_hu[j];
        end
        1, 2: begin
          // close to a stored template, so neighbors compete
          e = tmpl_elong[j] + FEAT_W'($urandom_range(0, 511)) - FEAT_W'(256);
          c = tmpl_circ[j] + FEAT_W'($urandom_range(0, 511)) - FEAT_W'(256);
          h = tmpl_hu[j] + FEAT_W'($urandom_range(0, 511)) - FEAT_W'(256);
        end
        3: begin
          e = FEAT_W'($urandom);
          c = FEAT_W'($urandom);
          h = FEAT_W'($urandom);
        end
        default: begin
          e = rand_feature();
          c = rand_feature();
          h = rand_feature();
        end
      endcase
      send_request(KIND_CLASSIFY, ADDR_W'($urandom), e, c, h, CLASS_W'($urandom), 1'b0,
                   NO_MATCH, pick_gap());
    end
  endtask

  function automatic logic [CNT_W-1:0] pick_count(int ph);
    case (ph)
      0: return CNT_W'(64);
      1: return CNT_W'(127);
      2: return CNT_W'(0);
      3: return CNT_W'(65);
      4: return CNT_W'(1);
      5: return CNT_W'(2);
      6: return CNT_W'(63);
      default: begin
        case ($urandom_range(0, 9))
          0: return CNT_W'(0);
          1: return CNT_W'(64);
          2: return CNT_W'($urandom_range(65, 127));
          3, 4, 5: return CNT_W'($urandom_range(1, 8));
          default: return CNT_W'($urandom_range(1, 63));
        endcase
      end
    endcase
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].op == ROW_CONFIG) begin
        drain();
        cfg_write(directed_rows[i].count);
      end else begin
        send_request(directed_rows[i].kind, directed_rows[i].idx, directed_rows[i].elong,
                     directed_rows[i].circ, directed_rows[i].hu, directed_rows[i].cls,
                     directed_rows[i].typed, directed_rows[i].want, 0);
      end
    end

    // fill the rest of the table while the scan still covers only the first four
    idling = 1'b1;
    for (int j = 4; j < MAX_TEMPLATES; j++) begin
      if ($urandom_range(0, 2) == 0)
        random_request();
      send_request(KIND_WRITE, ADDR_W'(j), rand_feature(), rand_feature(), rand_feature(),
                   CLASS_W'($urandom), 1'b0, NO_MATCH, pick_gap());
    end

    while (requests_accepted < RANDOM_REQUESTS - CALM_TAIL) begin
      drain();
      cfg_write(pick_count(phase));
      phase++;
      idling = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(15, 70)) random_request();
    end

    idling = 1'b0;
    drain();
    cfg_write(pick_count(phase));
    while (requests_accepted < RANDOM_REQUESTS)
      random_request();
    start <= 1'b0;

    while (pending_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/ntc_pkg.sv
design/ntc_ctrl.sv
design/ntc_datapath.sv
design/nearest_template_classifier.sv
tb/tb_top.sv
